[design/cls_pkg.sv]
// Shared types, request and status codes for the compacting list store.
`default_nettype none

package cls_pkg;

    // Default storage geometry.
    localparam int DEPTH_DEF      = 64;
    localparam int DATA_WIDTH_DEF = 32;

    // Entries gathered by one node of the first stage of the read tree.
    localparam int READ_GROUP = 8;

    // Fixed field widths of the request and result.
    localparam int INDEX_W     = 6;
    localparam int VALUE_W     = 32;
    localparam int SIZE_W      = 7;
    localparam int CAP_W       = 8;
    localparam int CFG_W       = 7;

    // Limits on the tracked capacity.
    localparam logic [CAP_W-1:0] CAP_MAX      = 8'd255;
    localparam logic [CFG_W-1:0] CAP_LOAD_MAX = 7'd64;

    // Request codes.
    localparam logic [1:0] REQ_APPEND = 2'd0;
    localparam logic [1:0] REQ_ERASE  = 2'd1;
    localparam logic [1:0] REQ_READ   = 2'd2;

    // Result status codes.
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_RANGE = 2'd2;

    typedef struct packed {
        logic [1:0]         req_type;
        logic [INDEX_W-1:0] index;
        logic [VALUE_W-1:0] value;
    } cls_req_t;

    typedef struct packed {
        logic [VALUE_W-1:0] read_value;
        logic [SIZE_W-1:0]  list_size;
        logic [CAP_W-1:0]   list_capacity;
        logic [1:0]         status;
    } cls_resp_t;

    // Command broadcast to every storage cell.
    typedef struct packed {
        logic append;
        logic erase;
    } cls_cell_cmd_t;

endpackage : cls_pkg

`default_nettype wire

[design/compacting_list_store.sv]
// Top level of the compacting list store: control, size and capacity tracking.
`default_nettype none

// The block keeps an ordered, packed list of up to DEPTH data words in a row
// of storage cells, one cell per position. Each request appends a word at the
// tail, erases the entry at an index, or reads the entry at an index, and gives
// exactly one result with the read word (zero unless a read succeeded), the
// size and the tracked capacity after the request, and a status. An erase
// closes the gap at the request edge: every entry above the erased place
// moves down one place. The capacity doubles (saturating at 255) when an
// append finds the list at or above it, and halves (never below one) when an
// erase leaves fewer than half of it in use. An append into a full store, or
// an erase or read at an index at or beyond the size, is flagged and changes
// nothing. The request edge updates the cells and captures the first level
// of the read tree. In the work state the selection over the cell groups
// completes and fills the result register once it is empty or its result is
// being taken; no new request is accepted until then. The result register
// lets the next request be taken while an earlier result still waits for
// m_ready. Writing the configuration register loads the capacity at once (0
// loads 1, anything above 64 loads 64); it must only be written while the
// block is idle. Entries need no clearing after reset: only positions below
// the size are ever read.
module compacting_list_store
    import cls_pkg::*;
#(
    parameter int DEPTH      = DEPTH_DEF,
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,

    input  wire logic             s_valid,
    output logic                  s_ready,
    input  wire cls_req_t         s_req,

    output logic                  m_valid,
    input  wire logic             m_ready,
    output cls_resp_t             m_resp,

    input  wire logic             cfg_wr_en,
    input  wire logic [CFG_W-1:0] cfg_wr_data
);

    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int IDX_W = $clog2(DEPTH);
    localparam int CMP_W = (CNT_W + 2 > CAP_W + 1) ? CNT_W + 2 : CAP_W + 1;

    typedef enum logic {
        S_IDLE,
        S_WORK
    } state_t;

    state_t             state_reg;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;
    logic [CAP_W-1:0]   cap_reg;
    logic [CAP_W-1:0]   cap_next;
    cls_resp_t          pend_reg;
    logic               pend_rd_reg;
    logic               m_valid_reg;
    cls_resp_t          m_resp_reg;

    logic               s_fire;
    logic               load_out;
    logic               full;
    logic               in_range;
    logic [1:0]         status;
    logic               rd_ok;
    logic [CMP_W-1:0]   idx_c;
    logic [CMP_W-1:0]   cnt_c;
    logic [CMP_W-1:0]   cap_c;
    logic [CMP_W-1:0]   cap_dbl;
    logic [CAP_W-1:0]   cfg_cap;

    cls_cell_cmd_t               cell_cmd;
    logic [CNT_W-1:0]            cell_index;
    logic [DATA_WIDTH-1:0]       cell_value;
    logic [DEPTH-1:0][DATA_WIDTH-1:0] cell_data;
    logic [DATA_WIDTH-1:0]       rd_data;

    assign s_ready = (state_reg == S_IDLE);
    assign s_fire  = s_valid && s_ready;

    // The result register is refilled in the work cycle once it is empty or
    // its current result is being taken.
    assign load_out = (state_reg == S_WORK) && (!m_valid_reg || m_ready);

    // Request decode: range checks and the next size and capacity.
    assign idx_c    = CMP_W'(s_req.index);
    assign cnt_c    = CMP_W'(count_reg);
    assign cap_c    = CMP_W'(cap_reg);
    assign cap_dbl  = cap_c << 1;
    assign full     = (count_reg == CNT_W'(DEPTH));
    assign in_range = (idx_c < cnt_c);

    always_comb begin
        count_next = count_reg;
        cap_next   = cap_reg;
        status     = ST_OK;
        rd_ok      = 1'b0;
        unique case (s_req.req_type)
            REQ_APPEND: begin
                if (full) begin
                    status = ST_FULL;
                end else begin
                    count_next = count_reg + CNT_W'(1);
                    if (cnt_c >= cap_c) begin
                        cap_next = (cap_dbl > CMP_W'(CAP_MAX)) ? CAP_MAX : CAP_W'(cap_dbl);
                    end
                end
            end
            REQ_ERASE: begin
                if (!in_range) begin
                    status = ST_RANGE;
                end else begin
                    count_next = count_reg - CNT_W'(1);
                    if (((cnt_c - CMP_W'(1)) << 1) < cap_c) begin
                        cap_next = (cap_reg > CAP_W'(1)) ? (cap_reg >> 1) : CAP_W'(1);
                    end
                end
            end
            REQ_READ: begin
                if (!in_range) begin
                    status = ST_RANGE;
                end else begin
                    rd_ok = 1'b1;
                end
            end
            default: begin
                status = ST_OK;
            end
        endcase
    end

    // Configuration value clamped into the legal capacity range.
    always_comb begin
        if (cfg_wr_data == '0) begin
            cfg_cap = CAP_W'(1);
        end else if (cfg_wr_data > CAP_LOAD_MAX) begin
            cfg_cap = CAP_W'(CAP_LOAD_MAX);
        end else begin
            cfg_cap = CAP_W'(cfg_wr_data);
        end
    end

    // Command broadcast to the cell row; the cells act only on a valid request.
    assign cell_cmd.append = s_fire && (s_req.req_type == REQ_APPEND) && !full;
    assign cell_cmd.erase  = s_fire && (s_req.req_type == REQ_ERASE) && in_range;
    assign cell_index      = CNT_W'(s_req.index);
    assign cell_value      = DATA_WIDTH'(s_req.value);

    // The row of storage cells. The top cell never shifts, so its neighbour
    // input is tied off.
    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        logic [DATA_WIDTH-1:0] nbr;
        if (i == DEPTH - 1) begin : g_top
            assign nbr = '0;
        end else begin : g_mid
            assign nbr = cell_data[i+1];
        end

        cls_cell #(
            .DW    (DATA_WIDTH),
            .CNT_W (CNT_W),
            .POS   (i)
        ) u_cell (
            .aclk     (aclk),
            .cmd      (cell_cmd),
            .count    (count_reg),
            .index    (cell_index),
            .value    (cell_value),
            .nbr_data (nbr),
            .data     (cell_data[i])
        );
    end

    // The read tree captures its first level from the cells as they stand
    // before the request edge updates them.
    cls_reader #(
        .DEPTH (DEPTH),
        .DW    (DATA_WIDTH),
        .IDX_W (IDX_W)
    ) u_reader (
        .aclk      (aclk),
        .capture   (s_fire),
        .sel       (IDX_W'(s_req.index)),
        .cell_data (cell_data),
        .rd_data   (rd_data)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            cap_reg     <= CAP_W'(1);
            m_valid_reg <= 1'b0;
        end else begin
            if (load_out) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            // Configuration write wins; user writes only when idle; not enforced.
            if (cfg_wr_en) begin
                cap_reg <= cfg_cap;
            end else if (s_fire) begin
                cap_reg <= cap_next;
            end
            unique case (state_reg)
                S_IDLE: begin
                    if (s_fire) begin
                        count_reg              <= count_next;
                        pend_reg.read_value    <= '0;
                        pend_reg.list_size     <= SIZE_W'(count_next);
                        pend_reg.list_capacity <= cap_next;
                        pend_reg.status        <= status;
                        pend_rd_reg            <= rd_ok;
                        state_reg              <= S_WORK;
                    end
                end
                S_WORK: begin
                    if (load_out) begin
                        m_resp_reg.read_value    <= pend_rd_reg ? VALUE_W'(rd_data)
                                                                : pend_reg.read_value;
                        m_resp_reg.list_size     <= pend_reg.list_size;
                        m_resp_reg.list_capacity <= pend_reg.list_capacity;
                        m_resp_reg.status        <= pend_reg.status;
                        state_reg                <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign m_valid = m_valid_reg;
    assign m_resp  = m_resp_reg;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(DEPTH))
        else $error("list size beyond storage depth");

    a_cap_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        cap_reg != '0)
        else $error("tracked capacity fell to zero");

    a_fire_work: assert property (@(posedge aclk) disable iff (!aresetn)
        s_fire |=> state_reg == S_WORK)
        else $error("accepted request did not enter the work cycle");

    a_erase_shrinks: assert property (@(posedge aclk) disable iff (!aresetn)
        cell_cmd.erase |=> count_reg == $past(count_reg) - CNT_W'(1))
        else $error("erase did not shrink the list by one");

    a_full_size: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_resp.status == ST_FULL) |-> m_resp.list_size == SIZE_W'(DEPTH))
        else $error("store full reported below depth");
`endif

endmodule : compacting_list_store

`default_nettype wire

[design/cls_cell.sv]
// One storage cell of the list: holds the entry at a fixed position.
`default_nettype none

module cls_cell
    import cls_pkg::*;
#(
    parameter int DW    = DATA_WIDTH_DEF,
    parameter int CNT_W = 7,
    parameter int POS   = 0
) (
    input  wire logic          aclk,
    input  wire cls_cell_cmd_t cmd,
    input  wire logic [CNT_W-1:0] count,
    input  wire logic [CNT_W-1:0] index,
    input  wire logic [DW-1:0] value,
    input  wire logic [DW-1:0] nbr_data,
    output logic [DW-1:0]      data
);

    logic [DW-1:0] data_reg;
    logic [DW-1:0] data_next;
    logic          take_value;
    logic          take_nbr;

    // The tail cell takes the appended word; cells from the erased place up
    // to the one below the last entry take the word of their upper neighbour.
    assign take_value = cmd.append && (count == CNT_W'(POS));
    assign take_nbr   = cmd.erase && (index <= CNT_W'(POS)) && (CNT_W'(POS + 1) < count);

    always_comb begin
        data_next = data_reg;
        if (take_nbr) begin
            data_next = nbr_data;
        end else if (take_value) begin
            data_next = value;
        end
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
    end

    assign data = data_reg;

endmodule : cls_cell

`default_nettype wire

[design/cls_reader.sv]
// Two-level read tree that selects one cell's word by position.
`default_nettype none

module cls_reader
    import cls_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF,
    parameter int DW    = DATA_WIDTH_DEF,
    parameter int IDX_W = 6
) (
    input  wire logic                      aclk,
    input  wire logic                      capture,
    input  wire logic [IDX_W-1:0]          sel,
    input  wire logic [DEPTH-1:0][DW-1:0]  cell_data,
    output logic [DW-1:0]                  rd_data
);

    localparam int NGRP = (DEPTH + READ_GROUP - 1) / READ_GROUP;

    logic [NGRP-1:0][DW-1:0] grp_reg;
    logic [NGRP-1:0][DW-1:0] grp_next;

    // First level: each group picks out the selected word, if it holds it.
    always_comb begin
        int p;
        for (int g = 0; g < NGRP; g++) begin
            grp_next[g] = '0;
            for (int k = 0; k < READ_GROUP; k++) begin
                p = g * READ_GROUP + k;
                if (p < DEPTH) begin
                    if (IDX_W'(p) == sel) begin
                        grp_next[g] = grp_next[g] | cell_data[IDX_W'(p)];
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (capture) begin
            grp_reg <= grp_next;
        end
    end

    // Second level: only one group can hold a non-zero word.
    always_comb begin
        rd_data = '0;
        for (int g = 0; g < NGRP; g++) begin
            rd_data = rd_data | grp_reg[g];
        end
    end

endmodule : cls_reader

`default_nettype wire
